[hw/rtl/obm_pkg.sv]
// Shared constants and types of the order book level matcher.
package obm_pkg;

   localparam int MaxLevels = 64;
   localparam int IdxW      = 6;
   localparam int GroupW    = 8;
   localparam int GroupN    = MaxLevels / GroupW;
   localparam int SelW      = 3;
   localparam int VolW      = 24;
   localparam int LiqW      = 25;

   localparam logic [VolW-1:0] VolMax = {VolW{1'b1}};

   localparam logic FuncLimit  = 1'b0;
   localparam logic FuncMarket = 1'b1;
   localparam logic SideBid    = 1'b1;
   localparam logic SideAsk    = 1'b0;

   localparam int ReqTickLsb = 0;
   localparam int ReqVolLsb  = ReqTickLsb + IdxW;
   localparam int ReqDataW   = 32;

   localparam int RspTickLsb = 0;
   localparam int RspVolLsb  = RspTickLsb + IdxW;
   localparam int RspRemLsb  = RspVolLsb + VolW;
   localparam int RspLiqLsb  = RspRemLsb + VolW;
   localparam int RspDataW   = 80;

   typedef struct packed {
      logic            found;
      logic [IdxW-1:0] idx;
   } enc_result_type;

endpackage

[hw/rtl/obm_prio_enc.sv]
// Lowest-set-bit encoder over the padded level occupancy vector, two levels of eight.
module obm_prio_enc (
   input  logic [obm_pkg::MaxLevels-1:0] vec,
   output obm_pkg::enc_result_type       result
);

   logic [obm_pkg::GroupN-1:0] grp_any;
   logic [obm_pkg::SelW-1:0]   grp_sel;
   logic [obm_pkg::GroupW-1:0] grp_bits;
   logic [obm_pkg::SelW-1:0]   bit_sel;

   always_comb begin
      for (int g = 0; g < obm_pkg::GroupN; g++) begin
         grp_any[g] = |vec[g*obm_pkg::GroupW +: obm_pkg::GroupW];
      end
      grp_sel = '0;
      for (int g = obm_pkg::GroupN - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = obm_pkg::SelW'(g);
         end
      end
      grp_bits = vec[{grp_sel, 3'b000} +: obm_pkg::GroupW];
      bit_sel = '0;
      for (int b = obm_pkg::GroupW - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = obm_pkg::SelW'(b);
         end
      end
      result.found = |grp_any;
      result.idx   = {grp_sel, bit_sel};
   end

endmodule

[hw/rtl/order_book_level_matcher_top.sv]
// Top level of the aggregated price-level order book with market order matching.
//
// Usage: the req channel takes one beat per order. tuser carries the function
// (limit add or market) and the side; tdata carries the price tick and the volume.
// The rsp channel gives one beat per level filled by a market order, or one beat
// for a limit add or a market order that fills nothing. The final beat of an
// order has tlast set and carries the remaining volume and the top-of-book
// liquidity (best bid volume plus best ask volume).
// Sequence: a limit add reads its level and writes the saturated sum back; a
// market order finds, subtracts and writes back each level it fills. Both end by
// reading the best bid and best ask and adding them. The sequencer uses the single
// shared adder, the level search encoder and each side's one level memory read port in turn.
// The block takes one order at a time; req_tready is high only while it is idle,
// and a new order can be taken while the last result beat still waits.
// Reset: all levels read as empty at once, since per-level occupancy flags are
// cleared; no clearing pass runs. A stalled rsp side holds its beat and the
// sequencer waits before loading the next one.
module order_book_level_matcher_top #(
   parameter int NUM_LEVELS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: price_tick[5:0], order_volume[29:6], zero pad.
   input  logic [obm_pkg::ReqDataW-1:0]  req_tdata,
   // Fields from bit 0: func, side.
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: exec_price_tick[5:0], exec_volume[29:6],
   // remaining_volume[53:30], liquidity[78:54], zero pad.
   output logic [obm_pkg::RspDataW-1:0]  rsp_tdata,
   // Fields from bit 0: executed.
   output logic [0:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int LvlW = $clog2(NUM_LEVELS);

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StLWr   = 4'd1;
   localparam logic [3:0] StMFind = 4'd2;
   localparam logic [3:0] StMSub1 = 4'd3;
   localparam logic [3:0] StMSub2 = 4'd4;
   localparam logic [3:0] StMWr   = 4'd5;
   localparam logic [3:0] StQBid  = 4'd6;
   localparam logic [3:0] StQAsk  = 4'd7;
   localparam logic [3:0] StQSum  = 4'd8;

   logic [3:0]                   state_ff, state_in;
   logic                         func_ff, func_in;
   logic                         side_ff, side_in;
   logic [obm_pkg::IdxW-1:0]     tick_ff, tick_in;
   logic                         lim_ok_ff, lim_ok_in;
   logic [obm_pkg::VolW-1:0]     vol_ff, vol_in;
   logic [obm_pkg::IdxW-1:0]     lvl_ff, lvl_in;
   logic [obm_pkg::VolW-1:0]     take_ff, take_in;
   logic [obm_pkg::VolW-1:0]     newlvl_ff, newlvl_in;
   logic                         pend_ff, pend_in;
   logic                         have_bid_ff, have_bid_in;
   logic                         have_ask_ff, have_ask_in;

   logic [obm_pkg::VolW-1:0]     bid_level_ff [NUM_LEVELS];
   logic [obm_pkg::VolW-1:0]     ask_level_ff [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]        bid_occ_ff;
   logic [NUM_LEVELS-1:0]        ask_occ_ff;
   logic [obm_pkg::VolW-1:0]     bid_rd_ff;
   logic [obm_pkg::VolW-1:0]     ask_rd_ff;

   logic                         bid_rd_en, ask_rd_en;
   logic [LvlW-1:0]              bid_rd_addr, ask_rd_addr;
   logic                         bid_wr_en, ask_wr_en;
   logic [LvlW-1:0]              wr_addr;
   logic [obm_pkg::VolW-1:0]     wr_data;

   logic                         rsp_valid_ff;
   logic [obm_pkg::RspDataW-1:0] rsp_data_ff;
   logic                         rsp_exec_ff;
   logic                         rsp_last_ff;
   logic                         out_load;
   logic                         out_free;
   logic                         out_exec;
   logic [obm_pkg::IdxW-1:0]     out_tick;
   logic [obm_pkg::VolW-1:0]     out_vol;
   logic [obm_pkg::VolW-1:0]     out_rem;
   logic [obm_pkg::LiqW-1:0]     out_liq;
   logic                         out_last;

   logic [obm_pkg::VolW-1:0]     alu_a, alu_b;
   logic                         alu_sub;
   logic [obm_pkg::LiqW-1:0]     alu_res;

   logic [obm_pkg::MaxLevels-1:0] bid_pad, ask_pad, bid_rev, enc_vec;
   logic                          enc_hi;
   obm_pkg::enc_result_type       enc;
   logic [obm_pkg::IdxW-1:0]      best_idx;

   logic                         req_accept;
   logic                         go;
   logic [obm_pkg::VolW-1:0]     avail;
   logic [obm_pkg::IdxW-1:0]     req_tick;
   logic [obm_pkg::VolW-1:0]     req_vol;

   assign req_tick   = req_tdata[obm_pkg::ReqTickLsb +: obm_pkg::IdxW];
   assign req_vol    = req_tdata[obm_pkg::ReqVolLsb +: obm_pkg::VolW];
   assign req_tready = (state_ff == StIdle);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign avail      = (side_ff == obm_pkg::SideBid) ? ask_rd_ff : bid_rd_ff;

   // Shared adder: a + b, or a - b with the borrow in the top bit.
   assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {obm_pkg::LiqW{alu_sub}})
                    + obm_pkg::LiqW'(alu_sub);

   always_comb begin
      bid_pad = obm_pkg::MaxLevels'(bid_occ_ff);
      ask_pad = obm_pkg::MaxLevels'(ask_occ_ff);
      for (int i = 0; i < obm_pkg::MaxLevels; i++) begin
         bid_rev[i] = bid_pad[obm_pkg::MaxLevels-1-i];
      end
      enc_hi   = ((state_ff == StMFind) && (side_ff == obm_pkg::SideAsk))
                 || (state_ff == StQBid);
      enc_vec  = enc_hi ? bid_rev : ask_pad;
      best_idx = enc_hi ? ~enc.idx : enc.idx;
   end

   obm_prio_enc u_enc (
      .vec    (enc_vec),
      .result (enc)
   );

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      side_in     = side_ff;
      tick_in     = tick_ff;
      lim_ok_in   = lim_ok_ff;
      vol_in      = vol_ff;
      lvl_in      = lvl_ff;
      take_in     = take_ff;
      newlvl_in   = newlvl_ff;
      pend_in     = pend_ff;
      have_bid_in = have_bid_ff;
      have_ask_in = have_ask_ff;
      bid_rd_en   = 1'b0;
      ask_rd_en   = 1'b0;
      bid_rd_addr = '0;
      ask_rd_addr = '0;
      bid_wr_en   = 1'b0;
      ask_wr_en   = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      alu_a       = '0;
      alu_b       = '0;
      alu_sub     = 1'b0;
      out_load    = 1'b0;
      out_exec    = 1'b0;
      out_tick    = '0;
      out_vol     = '0;
      out_rem     = '0;
      out_liq     = '0;
      out_last    = 1'b0;
      go          = enc.found && (vol_ff != '0);
      unique case (state_ff)
         StIdle: begin
            if (req_accept) begin
               func_in   = req_tuser[0];
               side_in   = req_tuser[1];
               tick_in   = req_tick;
               vol_in    = req_vol;
               lim_ok_in = ({1'b0, req_tick} < (obm_pkg::IdxW + 1)'(NUM_LEVELS));
               pend_in   = 1'b0;
               if (req_tuser[0] == obm_pkg::FuncLimit) begin
                  if (req_tuser[1] == obm_pkg::SideBid) begin
                     bid_rd_en   = 1'b1;
                     bid_rd_addr = req_tick[LvlW-1:0];
                  end else begin
                     ask_rd_en   = 1'b1;
                     ask_rd_addr = req_tick[LvlW-1:0];
                  end
                  state_in = StLWr;
               end else begin
                  state_in = StMFind;
               end
            end
         end
         StLWr: begin
            alu_a   = (side_ff == obm_pkg::SideBid) ? bid_rd_ff : ask_rd_ff;
            alu_b   = vol_ff;
            wr_addr = tick_ff[LvlW-1:0];
            wr_data = alu_res[obm_pkg::VolW] ? obm_pkg::VolMax : alu_res[obm_pkg::VolW-1:0];
            if (lim_ok_ff) begin
               bid_wr_en = (side_ff == obm_pkg::SideBid);
               ask_wr_en = (side_ff == obm_pkg::SideAsk);
            end
            state_in = StQBid;
         end
         StMFind: begin
            if (go) begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     out_load = 1'b1;
                     out_exec = 1'b1;
                     out_tick = lvl_ff;
                     out_vol  = take_ff;
                     out_rem  = vol_ff;
                     pend_in  = 1'b0;
                  end
                  if (side_ff == obm_pkg::SideBid) begin
                     ask_rd_en   = 1'b1;
                     ask_rd_addr = best_idx[LvlW-1:0];
                  end else begin
                     bid_rd_en   = 1'b1;
                     bid_rd_addr = best_idx[LvlW-1:0];
                  end
                  lvl_in   = best_idx;
                  state_in = StMSub1;
               end
            end else begin
               state_in = StQBid;
            end
         end
         StMSub1: begin
            alu_a   = vol_ff;
            alu_b   = avail;
            alu_sub = 1'b1;
            if (!alu_res[obm_pkg::VolW]) begin
               take_in   = avail;
               newlvl_in = '0;
               vol_in    = alu_res[obm_pkg::VolW-1:0];
               state_in  = StMWr;
            end else begin
               take_in  = vol_ff;
               state_in = StMSub2;
            end
         end
         StMSub2: begin
            alu_a     = avail;
            alu_b     = vol_ff;
            alu_sub   = 1'b1;
            newlvl_in = alu_res[obm_pkg::VolW-1:0];
            vol_in    = '0;
            state_in  = StMWr;
         end
         StMWr: begin
            wr_addr   = lvl_ff[LvlW-1:0];
            wr_data   = newlvl_ff;
            bid_wr_en = (side_ff == obm_pkg::SideAsk);
            ask_wr_en = (side_ff == obm_pkg::SideBid);
            pend_in   = 1'b1;
            state_in  = StMFind;
         end
         StQBid: begin
            have_bid_in = enc.found;
            bid_rd_en   = 1'b1;
            bid_rd_addr = best_idx[LvlW-1:0];
            state_in    = StQAsk;
         end
         StQAsk: begin
            have_ask_in = enc.found;
            ask_rd_en   = 1'b1;
            ask_rd_addr = best_idx[LvlW-1:0];
            state_in    = StQSum;
         end
         StQSum: begin
            alu_a = bid_rd_ff;
            alu_b = ask_rd_ff;
            if (out_free) begin
               out_load = 1'b1;
               out_exec = pend_ff;
               out_tick = pend_ff ? lvl_ff : '0;
               out_vol  = pend_ff ? take_ff : '0;
               out_rem  = (func_ff == obm_pkg::FuncMarket) ? vol_ff : '0;
               out_liq  = (have_bid_ff && have_ask_ff) ? alu_res : '0;
               out_last = 1'b1;
               pend_in  = 1'b0;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      func_ff     <= func_in;
      side_ff     <= side_in;
      tick_ff     <= tick_in;
      lim_ok_ff   <= lim_ok_in;
      vol_ff      <= vol_in;
      lvl_ff      <= lvl_in;
      take_ff     <= take_in;
      newlvl_ff   <= newlvl_in;
      have_bid_ff <= have_bid_in;
      have_ask_ff <= have_ask_in;
   end

   // An empty level reads as zero, so an entry never written is never seen.
   always_ff @(posedge clock) begin
      if (bid_wr_en) begin
         bid_level_ff[wr_addr] <= wr_data;
      end
      if (bid_rd_en) begin
         bid_rd_ff <= bid_occ_ff[bid_rd_addr] ? bid_level_ff[bid_rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ask_wr_en) begin
         ask_level_ff[wr_addr] <= wr_data;
      end
      if (ask_rd_en) begin
         ask_rd_ff <= ask_occ_ff[ask_rd_addr] ? ask_level_ff[ask_rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bid_occ_ff <= '0;
         ask_occ_ff <= '0;
      end else begin
         if (bid_wr_en) begin
            bid_occ_ff[wr_addr] <= (wr_data != '0);
         end
         if (ask_wr_en) begin
            ask_occ_ff[wr_addr] <= (wr_data != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= obm_pkg::RspDataW'({out_liq, out_rem, out_vol, out_tick});
         rsp_exec_ff <= out_exec;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_exec_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hw/rtl/obm_checker.sv]
// Port-level checker of the order book level matcher and its bind.
module obm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [obm_pkg::RspDataW-1:0] rsp_tdata,
   input logic [0:0]                   rsp_tuser,
   input logic                         rsp_tlast
);

   logic [obm_pkg::LiqW-1:0] liq;
   logic [obm_pkg::VolW-1:0] exec_vol;

   assign liq      = rsp_tdata[obm_pkg::RspLiqLsb +: obm_pkg::LiqW];
   assign exec_vol = rsp_tdata[obm_pkg::RspVolLsb +: obm_pkg::VolW];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result beat valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result beat changed.");

   a_nofill_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (exec_vol == '0))
      else $error("Beat without a fill is not the final beat of its order.");

   a_mid_no_liq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (liq == '0) && (exec_vol != '0))
      else $error("Intermediate fill beat carries liquidity or no volume.");

   a_busy_mid_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("New order taken while an order is still producing fills.");

endmodule

bind order_book_level_matcher_top obm_checker u_obm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[tb/tb_order_book_level_matcher_top.sv]
// Self-checking testbench of the order book level matcher against a book model.
module tb_order_book_level_matcher_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Levels      = obm_pkg::MaxLevels;
   localparam int RandomItems = 260;
   localparam int HoldCycles  = 300;
   localparam int StallLimit  = 5000;
   localparam int TailCycles  = 20;
   localparam int IdlePercent = 27;

   typedef struct {
      logic                     executed;
      logic [obm_pkg::IdxW-1:0] tick;
      logic [obm_pkg::VolW-1:0] fill_vol;
      logic [obm_pkg::VolW-1:0] remaining;
      logic [obm_pkg::LiqW-1:0] liquidity;
      logic                     last;
   } fill_beat_type;

   class order_book_scoreboard;
      fill_beat_type            expected_fills[$];
      logic [obm_pkg::VolW-1:0] bid_vol[Levels];
      logic [obm_pkg::VolW-1:0] ask_vol[Levels];
      int                       mismatches;

      function new();
         for (int i = 0; i < Levels; i++) begin
            bid_vol[i] = '0;
            ask_vol[i] = '0;
         end
         mismatches = 0;
      endfunction

      function logic [obm_pkg::LiqW-1:0] top_liquidity();
         logic [obm_pkg::VolW-1:0] best_bid;
         logic [obm_pkg::VolW-1:0] best_ask;
         best_bid = '0;
         best_ask = '0;
         for (int i = Levels - 1; i >= 0; i--) begin
            if (best_bid == 0) best_bid = bid_vol[i];
         end
         for (int i = 0; i < Levels; i++) begin
            if (best_ask == 0) best_ask = ask_vol[i];
         end
         if (best_bid == 0 || best_ask == 0) return '0;
         return {1'b0, best_bid} + {1'b0, best_ask};
      endfunction

      function void note_order(logic func, logic side, logic [obm_pkg::IdxW-1:0] tick,
                               logic [obm_pkg::VolW-1:0] vol);
         fill_beat_type            beat;
         logic [obm_pkg::VolW:0]   sum;
         logic [obm_pkg::VolW-1:0] avail;
         logic [obm_pkg::VolW-1:0] take;
         int                       lvl;
         int                       count;
         count = 0;
         if (func == obm_pkg::FuncLimit) begin
            if (tick < Levels) begin
               sum = side == obm_pkg::SideBid ? {1'b0, bid_vol[tick]} + {1'b0, vol}
                                              : {1'b0, ask_vol[tick]} + {1'b0, vol};
               if (sum > obm_pkg::VolMax) sum = {1'b0, obm_pkg::VolMax};
               if (side == obm_pkg::SideBid) bid_vol[tick] = sum[obm_pkg::VolW-1:0];
               else ask_vol[tick] = sum[obm_pkg::VolW-1:0];
            end
            beat = '{1'b0, '0, '0, '0, top_liquidity(), 1'b1};
            expected_fills.push_back(beat);
            return;
         end
         for (int i = 0; i < Levels && vol > 0; i++) begin
            lvl = side == obm_pkg::SideBid ? i : Levels - 1 - i;
            avail = side == obm_pkg::SideBid ? ask_vol[lvl] : bid_vol[lvl];
            if (avail != 0) begin
               take = vol < avail ? vol : avail;
               if (side == obm_pkg::SideBid) ask_vol[lvl] = avail - take;
               else bid_vol[lvl] = avail - take;
               vol = vol - take;
               beat = '{1'b1, lvl[obm_pkg::IdxW-1:0], take, vol, '0, 1'b0};
               expected_fills.push_back(beat);
               count++;
            end
         end
         if (count == 0) begin
            beat = '{1'b0, '0, '0, vol, top_liquidity(), 1'b1};
            expected_fills.push_back(beat);
         end else begin
            expected_fills[$].liquidity = top_liquidity();
            expected_fills[$].last = 1'b1;
         end
      endfunction

      function void check_fill(logic [obm_pkg::RspDataW-1:0] data, logic executed,
                               logic last);
         fill_beat_type got;
         fill_beat_type exp;
         got.executed  = executed;
         got.tick      = data[obm_pkg::RspTickLsb +: obm_pkg::IdxW];
         got.fill_vol  = data[obm_pkg::RspVolLsb +: obm_pkg::VolW];
         got.remaining = data[obm_pkg::RspRemLsb +: obm_pkg::VolW];
         got.liquidity = data[obm_pkg::RspLiqLsb +: obm_pkg::LiqW];
         got.last      = last;
         if (expected_fills.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: exe=%0d tick=%0d vol=%0d rem=%0d %s%0d %s%0d",
                        got.executed, got.tick, got.fill_vol, got.remaining,
                        "liq=", got.liquidity, "last=", got.last);
            return;
         end
         exp = expected_fills.pop_front();
         if (got.executed !== exp.executed || got.tick !== exp.tick ||
             got.fill_vol !== exp.fill_vol || got.remaining !== exp.remaining ||
             got.liquidity !== exp.liquidity || got.last !== exp.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: expected exe=%0d tick=%0d vol=%0d rem=%0d liq=%0d last=%0d",
                        exp.executed, exp.tick, exp.fill_vol, exp.remaining,
                        exp.liquidity, exp.last);
               $display("          got      exe=%0d tick=%0d vol=%0d rem=%0d liq=%0d last=%0d",
                        got.executed, got.tick, got.fill_vol, got.remaining,
                        got.liquidity, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_fills.size();
      endfunction
   endclass

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [obm_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic [1:0]                   req_tuser  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [obm_pkg::RspDataW-1:0] rsp_tdata;
   logic [0:0]                   rsp_tuser;
   logic                         rsp_tlast;

   order_book_scoreboard sb = new();
   bit                   calm = 1'b0;
   bit                   hold_req = 1'b0;
   int                   stall_cycles = 0;

   order_book_level_matcher_top #(.NUM_LEVELS(Levels)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic send_order(input logic func, input logic side,
                             input logic [obm_pkg::IdxW-1:0] tick,
                             input logic [obm_pkg::VolW-1:0] vol);
      while (!calm && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {side, func};
      req_tdata  <= obm_pkg::ReqDataW'({vol, tick});
      do @(posedge clock); while (!req_tready);
      sb.note_order(func, side, tick, vol);
   endtask

   function automatic logic [obm_pkg::VolW-1:0] pick_volume(int small_max);
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return obm_pkg::VolW'($urandom_range(small_max, 1));
      if (roll < 82) return obm_pkg::VolW'($urandom);
      if (roll < 92) return obm_pkg::VolMax;
      return '0;
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= reset ? 1'b0 : (calm || $urandom_range(99) >= IdlePercent);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_fill(rsp_tdata, rsp_tuser[0], rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < StallLimit) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic func;
      logic side;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_order(obm_pkg::FuncMarket, obm_pkg::SideBid, 6'd0, 24'd100);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideAsk, 6'd63, obm_pkg::VolMax);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd0, 24'd0);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd63, 24'd1);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd0, obm_pkg::VolMax);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd0, 24'd5);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd63, obm_pkg::VolMax);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd10, 24'd1000);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd11, 24'd2000);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd40, 24'd300);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd41, 24'd400);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideBid, 6'd21, 24'd0);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideBid, 6'd42, 24'd1500);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideAsk, 6'd0, 24'd500);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideBid, 6'd63, obm_pkg::VolMax);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideAsk, 6'd63, obm_pkg::VolMax);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideAsk, 6'd0, obm_pkg::VolMax);
      send_order(obm_pkg::FuncMarket, obm_pkg::SideBid, 6'd0, 24'd1);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd0, 24'd7);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd63, 24'd9);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideBid, 6'd62, 24'hAAAAAA);
      send_order(obm_pkg::FuncLimit, obm_pkg::SideAsk, 6'd1, 24'h555555);

      for (int n = 0; n < RandomItems; n++) begin
         if (n == 60) hold_req = 1'b1;
         if (n == 120) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         if (n == 170) calm = 1'b1;
         if (n == 220) calm = 1'b0;
         side = 1'($urandom_range(1, 0));
         if ($urandom_range(99) < 60) begin
            func = obm_pkg::FuncLimit;
            send_order(func, side, obm_pkg::IdxW'($urandom_range(Levels - 1, 0)),
                       pick_volume(5000));
         end else begin
            func = obm_pkg::FuncMarket;
            send_order(func, side, obm_pkg::IdxW'($urandom_range(Levels - 1, 0)),
                       pick_volume(15000));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
